// ===== design/hbm_pkg.sv =====
// Shared types and constants of the heartbeat liveness monitor.
package hbm_pkg;

  localparam int DEF_NUM_SERVICES = 16;

  localparam int SVC_ID_W  = 16;
  localparam int MASK_W    = 16;
  localparam int ELAPSED_W = 12;
  localparam int TIMEOUT_W = 12;
  localparam int PERIOD_W  = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 12'd1250;
  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 10'd100;

  typedef enum logic {
    FUNC_HEARTBEAT = 1'b0,
    FUNC_TICK      = 1'b1
  } hbm_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_MS   = 1'b0,
    CFG_CHECK_PERIOD = 1'b1
  } hbm_cfg_idx_t;

  // Per-service counter control
  typedef struct packed {
    logic tick;
    logic clear;
  } hbm_cell_ctrl_t;

endpackage

// ===== design/hbm_ifs.sv =====
// Stream interfaces for heartbeat/tick items and liveness results.
interface hbm_req_if import hbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [SVC_ID_W-1:0] svc_id;

  modport source (output valid, func, svc_id, input ready);
  modport sink   (input valid, func, svc_id, output ready);
endinterface

interface hbm_rsp_if import hbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] alive_mask;
  logic              notify;
  logic              ignored;

  modport source (output valid, alive_mask, notify, ignored, input ready);
  modport sink   (input valid, alive_mask, notify, ignored, output ready);
endinterface

// ===== design/heartbeat_liveness_monitor.sv =====
// Top level of the heartbeat liveness monitor.
//
//   channel  dir   payload                          accepted when
//   req      in    func, svc_id                     req.valid && req.ready
//   rsp      out   alive_mask, notify, ignored      rsp.valid && rsp.ready
//   cfg      in    cfg_index, cfg_wdata             cfg_we
//
// One item per cycle unless rsp stalls: the state updates and the result
// register loads at the accepting edge, visible in the cycle after. The result
// register holds under stall; req.ready stays high while free or being taken.
// Synchronous reset clears flags, counters, phase and loads register defaults.
module heartbeat_liveness_monitor import hbm_pkg::*; #(
  parameter int NUM_SERVICES = DEF_NUM_SERVICES
) (
  input  logic                  clk,
  input  logic                  rst,
  hbm_req_if.sink               req,
  hbm_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIMEOUT_W-1:0]    timeout_ms;
  logic [PERIOD_W-1:0]     check_period;
  logic [NUM_SERVICES-1:0] known;
  logic [NUM_SERVICES-1:0] active;
  logic [NUM_SERVICES-1:0] known_next;
  logic [NUM_SERVICES-1:0] active_next;
  logic [NUM_SERVICES-1:0] hit;
  logic [NUM_SERVICES-1:0] expired;
  logic [PERIOD_W-1:0]     phase;
  logic [PERIOD_W-1:0]     phase_inc;
  logic [PERIOD_W-1:0]     phase_next;
  logic [PERIOD_W-1:0]     period;
  logic [MASK_W-1:0]       mask_next;
  logic                    accept;
  logic                    is_tick;
  logic                    is_beat;
  logic                    check;
  logic                    notify_next;
  logic                    ignored_next;

  logic                    rsp_valid;
  logic [MASK_W-1:0]       alive_mask;
  logic                    notify;
  logic                    ignored;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_tick   = req.func == FUNC_TICK;
  assign is_beat   = req.func == FUNC_HEARTBEAT;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms   <= TIMEOUT_RST;
      check_period <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_MS:   timeout_ms   <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_CHECK_PERIOD: check_period <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // per-service decode and counters
  for (genvar n = 0; n < NUM_SERVICES; n++) begin : g_svc
    hbm_cell_ctrl_t ctrl;

    assign hit[n]     = is_beat && req.svc_id == SVC_ID_W'(n + 1);
    assign ctrl.clear = accept && hit[n];
    assign ctrl.tick  = accept && is_tick;

    hbm_elapsed_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .timeout_ms (timeout_ms),
      .expired    (expired[n])
    );
  end

  // a zero period checks on every tick
  assign period    = (check_period == '0) ? PERIOD_W'(1) : check_period;
  assign phase_inc = phase + 1'b1;
  assign check     = is_tick && phase_inc >= period;

  always_comb begin
    phase_next = phase;
    if (is_tick) begin
      phase_next = check ? '0 : phase_inc;
    end
  end

  always_comb begin
    known_next  = known | hit;
    active_next = active | hit;
    if (check) begin
      active_next = active_next & ~(known & expired);
    end
  end

  assign notify_next  = |(hit & ~(known & active));
  assign ignored_next = is_beat && !(|hit);

  // only the low services show in the mask
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < NUM_SERVICES) begin : g_on
      assign mask_next[m] = active_next[m];
    end else begin : g_off
      assign mask_next[m] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known  <= '0;
      active <= '0;
      phase  <= '0;
    end else if (accept) begin
      known  <= known_next;
      active <= active_next;
      phase  <= phase_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alive_mask <= mask_next;
      notify     <= notify_next;
      ignored    <= ignored_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.alive_mask = alive_mask;
  assign rsp.notify     = notify;
  assign rsp.ignored    = ignored;

endmodule

// ===== design/hbm_elapsed_cell.sv =====
// Saturating per-service elapsed-millisecond counter with timeout compare.
module hbm_elapsed_cell import hbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  hbm_cell_ctrl_t       ctrl,
  input  logic [TIMEOUT_W-1:0] timeout_ms,
  output logic                 expired
);

  logic [ELAPSED_W-1:0] count;
  logic [ELAPSED_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.tick && count != ELAPSED_MAX) begin
      count_next = count + 1'b1;
    end
  end

  // compare against the advanced count, as the check follows the advance
  assign expired = count_next > timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== bench/heartbeat_liveness_monitor_tb.sv =====
// Self-checking testbench of the heartbeat liveness monitor: directed and random beats.
module heartbeat_liveness_monitor_tb import hbm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SVC_COUNT   = DEF_NUM_SERVICES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic              notify;
    logic              ignored;
  } liveness_status_t;

  // Tracks service liveness alongside the block and checks every result beat.
  class liveness_tracker;
    logic [SVC_COUNT-1:0] known;
    logic [SVC_COUNT-1:0] active;
    logic [ELAPSED_W-1:0] elapsed [SVC_COUNT];
    logic [PERIOD_W-1:0]  phase;
    logic [TIMEOUT_W-1:0] timeout;
    logic [PERIOD_W-1:0]  period;
    liveness_status_t     pending_status [$];
    int                   failures;

    function new();
      known    = '0;
      active   = '0;
      foreach (elapsed[n]) elapsed[n] = '0;
      phase    = '0;
      timeout  = TIMEOUT_RST;
      period   = PERIOD_RST;
      failures = 0;
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void write_reg(hbm_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TIMEOUT_MS:   timeout = data[TIMEOUT_W-1:0];
        CFG_CHECK_PERIOD: period  = data[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_beat(hbm_func_t func, logic [SVC_ID_W-1:0] id);
      liveness_status_t st;
      logic [PERIOD_W-1:0] span;
      st.notify  = 1'b0;
      st.ignored = 1'b0;
      if (func == FUNC_HEARTBEAT) begin
        if (id >= 1 && id <= SVC_COUNT) begin
          if (!known[id-1] || !active[id-1]) st.notify = 1'b1;
          known[id-1]   = 1'b1;
          active[id-1]  = 1'b1;
          elapsed[id-1] = '0;
        end else begin
          st.ignored = 1'b1;
        end
      end else begin
        // a period of zero checks on every tick
        span = (period == '0) ? PERIOD_W'(1) : period;
        foreach (elapsed[n]) if (elapsed[n] != ELAPSED_MAX) elapsed[n]++;
        phase = phase + 1'b1;
        if (phase >= span) begin
          phase = '0;
          foreach (elapsed[n]) if (known[n] && elapsed[n] > timeout) active[n] = 1'b0;
        end
      end
      st.mask = MASK_W'(active);
      pending_status.push_back(st);
    endfunction

    function void check_status(logic [MASK_W-1:0] mask, logic notify, logic ignored);
      liveness_status_t exp_st;
      if (pending_status.size() == 0) begin
        fail($sformatf("unexpected result: mask=%h notify=%b ignored=%b",
                       mask, notify, ignored));
        return;
      end
      exp_st = pending_status.pop_front();
      if (mask !== exp_st.mask || notify !== exp_st.notify || ignored !== exp_st.ignored)
        fail($sformatf({"mismatch: expected mask=%h notify=%b ignored=%b, ",
                        "got mask=%h notify=%b ignored=%b"},
                       exp_st.mask, exp_st.notify, exp_st.ignored, mask, notify, ignored));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    idle_pct  = 0;
  int                    stall_pct = 0;
  int unsigned           cycle_count = 0;
  liveness_tracker       tracker = new();

  int tmo_set [PHASES] = '{1, 4095, 6, 3, 10, 0, 2, 25};
  int per_set [PHASES] = '{1, 1023, 3, 12'hC02, 1, 4, 5, 12'h802};
  int idle_set [4]     = '{0, 54, 0, 33};
  int stall_set [4]    = '{0, 0, 54, 33};

  hbm_req_if req_ch ();
  hbm_rsp_if rsp_ch ();

  heartbeat_liveness_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_status(rsp_ch.alive_mask, rsp_ch.notify, rsp_ch.ignored);
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(hbm_func_t func, logic [SVC_ID_W-1:0] id);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.func   <= func;
    req_ch.svc_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_beat(func, id);
  endtask

  // Hold off the sender until every pending result has been taken.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] tmo, logic [CFG_DATA_W-1:0] per);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT_MS;
    cfg_wdata <= tmo;
    @(posedge clk);
    tracker.write_reg(CFG_TIMEOUT_MS, tmo);
    cfg_index <= CFG_CHECK_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    tracker.write_reg(CFG_CHECK_PERIOD, per);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    int done;
    int r;
    logic [SVC_ID_W-1:0] id;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 79) == 0) drain_results();
      if ($urandom_range(0, 99) < 55) begin
        send_item(FUNC_TICK, SVC_ID_W'($urandom()));
      end else begin
        // favor a few services so the rest age out and come back
        r = $urandom_range(0, 99);
        if (r < 65)      id = SVC_ID_W'($urandom_range(1, 6));
        else if (r < 85) id = SVC_ID_W'($urandom_range(7, SVC_COUNT));
        else if (r < 92) id = $urandom_range(0, 1) ? SVC_ID_W'(0) : SVC_ID_W'(SVC_COUNT + 1);
        else             id = SVC_ID_W'($urandom());
        send_item(FUNC_HEARTBEAT, id);
      end
      done++;
    end
  endtask

  initial begin
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.func   <= FUNC_HEARTBEAT;
    req_ch.svc_id <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_TIMEOUT_MS;
    cfg_wdata     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: first beats, repeats, ids at and past both ends
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(1));
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(1));
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(SVC_COUNT));
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(0));
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(SVC_COUNT + 1));
    send_item(FUNC_HEARTBEAT, 16'hFFFF);
    send_item(FUNC_HEARTBEAT, 16'h8000);
    send_item(FUNC_TICK, 16'hFFFF);
    send_item(FUNC_TICK, 16'h0000);
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(8));
    drain_results();

    // zero timeout and zero period: every known service dies on the next tick
    write_regs('0, '0);
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(5));
    send_item(FUNC_TICK, 16'h0000);
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(5));
    send_item(FUNC_HEARTBEAT, SVC_ID_W'(5));
    send_item(FUNC_TICK, 16'h5555);
    send_item(FUNC_TICK, 16'hAAAA);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = idle_set[p % 4];
      stall_pct = stall_set[p % 4];
      write_regs(CFG_DATA_W'(tmo_set[p]), CFG_DATA_W'(per_set[p]));
      run_random(140);
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (tracker.pending_status.size() != 0)
      tracker.fail($sformatf("%0d results never arrived", tracker.pending_status.size()));
    if (tracker.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
